FILE: hw/rtl/agd_pkg.sv
// Shared types, constants and arithmetic helpers for the algae growth derivative.
package agd_pkg;

  // Chain lengths and pipeline depth
  localparam int LOG_N    = 16;  // squaring cells per log2
  localparam int POW_N    = 16;  // fractional power cells
  localparam int DIV_N    = 31;  // quotient bits of the divider
  localparam int STAGES   = LOG_N + POW_N + DIV_N + 19;
  localparam int RS_DEPTH = LOG_N + POW_N + DIV_N + 14;

  localparam int CFG_AW = 3;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_GROWTH_RATE_MAX = 3'd0,
    REG_EC50            = 3'd1,
    REG_SLOPE           = 3'd2,
    REG_UPTAKE_RATE     = 3'd3,
    REG_USE_DAMAGE      = 3'd4,
    REG_CURVE_MODE      = 3'd5
  } cfg_reg_t;

  // Fixed-point constants, Q30 unless noted
  localparam logic [30:0] Q30_ONE          = 31'd1073741824;
  localparam logic [29:0] LN2_Q30          = 30'd744261118;
  localparam logic [29:0] HALF_LOG2E_Q30   = 30'd774541002;
  localparam logic [28:0] INV_SQRT_2PI_Q30 = 29'd428361012;
  localparam logic [27:0] PROBIT_P_Q30     = 28'd248723596;
  localparam logic signed [35:0] CB1 = 36'sd342933307;
  localparam logic signed [35:0] CB2 = -36'sd382857446;
  localparam logic signed [35:0] CB3 = 36'sd1912847370;
  localparam logic signed [35:0] CB4 = -36'sd1955558716;
  localparam logic signed [35:0] CB5 = 36'sd1428371292;
  localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Normalized operand moving through the log2 chain
  typedef struct packed {
    logic        zero;
    logic [4:0]  n;
    logic [31:0] m;
    logic [15:0] frac;
  } log_t;

  // Mantissa moving through the power-of-two chain
  typedef struct packed {
    logic        zero;
    logic [5:0]  sh;
    logic [15:0] fp;
    logic [30:0] m;
  } pow_t;

  // Restoring divider state
  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] num;
    logic [31:0] den;
    logic [30:0] quo;
  } div_t;

  // round(2^(30 + 2^-(k+1))), k = 0..15
  function automatic logic [30:0] pow2_frac(input logic [3:0] k);
    logic [30:0] r;
    case (k)
      4'd0:    r = 31'd1518500250;
      4'd1:    r = 31'd1276901417;
      4'd2:    r = 31'd1170923762;
      4'd3:    r = 31'd1121280436;
      4'd4:    r = 31'd1097253708;
      4'd5:    r = 31'd1085434106;
      4'd6:    r = 31'd1079572136;
      4'd7:    r = 31'd1076653033;
      4'd8:    r = 31'd1075196443;
      4'd9:    r = 31'd1074468888;
      4'd10:   r = 31'd1074105294;
      4'd11:   r = 31'd1073923544;
      4'd12:   r = 31'd1073832680;
      4'd13:   r = 31'd1073787251;
      4'd14:   r = 31'd1073764537;
      default: r = 31'd1073753181;
    endcase
    return r;
  endfunction

  // Position of the leading one
  function automatic logic [4:0] lead_one(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  // Signed Q30 product by an unsigned factor, rounded half away from zero
  function automatic logic signed [35:0] mul_q30(input logic signed [35:0] a,
                                                 input logic [30:0] b);
    logic        neg;
    logic [34:0] mag;
    logic [65:0] p;
    logic [35:0] r;
    neg = a[35];
    mag = neg ? 35'(-a) : 35'(a);
    p   = 66'(mag) * 66'(b);
    r   = 36'((p + 66'd536870912) >> 30);
    return neg ? -$signed(r) : $signed(r);
  endfunction

endpackage

FILE: hw/rtl/agd_log_cell.sv
// One squaring step of the fractional log2, yielding one result bit.
module agd_log_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  agd_pkg::log_t din,
  output agd_pkg::log_t dout
);
  import agd_pkg::*;

  logic [63:0] sq;
  logic [32:0] t;
  log_t        nxt;

  // Square, renormalize, emit bit
  always_comb begin
    sq  = 64'(din.m) * 64'(din.m);
    t   = sq[63:31];
    nxt = din;
    if (t[32]) begin
      nxt.frac[BIT] = 1'b1;
      nxt.m         = t[32:1];
    end else begin
      nxt.m = t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: hw/rtl/agd_pow_cell.sv
// One conditional multiply of the fractional power of two.
module agd_pow_cell #(
  parameter int K = 1
) (
  input  logic          clk,
  input  logic          en,
  input  agd_pkg::pow_t din,
  output agd_pkg::pow_t dout
);
  import agd_pkg::*;

  logic [62:0] p;
  pow_t        nxt;

  // Multiply by 2^(2^-K) when that bit of the fraction is set
  always_comb begin
    p   = 63'(din.m) * 63'(pow2_frac(4'(K - 1)));
    nxt = din;
    if (din.fp[16 - K]) begin
      nxt.m = 31'((p + 63'd536870912) >> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: hw/rtl/agd_div_cell.sv
// One restoring division step, one quotient bit.
module agd_div_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  agd_pkg::div_t din,
  output agd_pkg::div_t dout
);
  import agd_pkg::*;

  logic [32:0] t;
  div_t        nxt;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    t   = {din.rem, din.num[BIT]};
    nxt = din;
    if (t >= {1'b0, din.den}) begin
      nxt.rem      = 32'(t - {1'b0, din.den});
      nxt.quo[BIT] = 1'b1;
    end else begin
      nxt.rem = t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: hw/rtl/agd_delay.sv
// Enabled shift line that carries side data alongside a cell chain.
module agd_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);
  logic [W-1:0] sr [D];

  // Advance all taps together
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int i = 1; i < D; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign dout = sr[D-1];

endmodule

FILE: hw/rtl/algae_growth_derivative.sv
// Top level: pipelined growth and damage derivative with dose-response inhibition.
//
//   channel | dir | beat contents (low bits first)
//   s_*     | in  | biomass, damage, concentration, growth_factor (32 bits each)
//   m_*     | out | biomass_rate, damage_rate (32 bits each)
//   cfg_*   | in  | register write: index in cfg_addr, value in cfg_wdata
//
// One beat is taken per cycle unless a stalled output holds the pipeline; each beat
// passes 82 pipeline stages and then the output register. The depth is set by the
// chains of log2 squaring, power-of-two and divider cells.
// Reset clears the valid line and the output valid and loads the configuration defaults.
// A stalled output freezes the pipeline only once its last stage is full.
module algae_growth_derivative (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [127:0]               s_tdata,  // biomass, damage, concentration, growth_factor
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [63:0]                m_tdata,  // biomass_rate, damage_rate
  input  logic                       cfg_we,
  input  logic [agd_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [31:0]                cfg_wdata
);
  import agd_pkg::*;

  typedef struct packed {
    logic [30:0] k;
    logic [29:0] phi;
    logic        pos;
    logic        tail_ok;
    logic        xzero;
  } hz_t;

  typedef struct packed {
    logic [31:0] bio;
    logic [47:0] p1;
    logic [31:0] drate;
  } rs_t;

  // Configuration
  logic [31:0] growth_rate_max, ec50, slope, uptake_rate;
  logic        use_damage, curve_mode;

  logic              adv;
  logic [STAGES-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      growth_rate_max <= 32'd65536;
      ec50            <= 32'd65536;
      slope           <= 32'd65536;
      uptake_rate     <= 32'd0;
      use_damage      <= 1'b0;
      curve_mode      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_GROWTH_RATE_MAX: growth_rate_max <= cfg_wdata;
        REG_EC50:            ec50            <= cfg_wdata;
        REG_SLOPE:           slope           <= cfg_wdata;
        REG_UPTAKE_RATE:     uptake_rate     <= cfg_wdata;
        REG_USE_DAMAGE:      use_damage      <= cfg_wdata[0];
        REG_CURVE_MODE:      curve_mode      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Advance when the last stage is empty or the output register frees up
  assign adv      = !vld[STAGES-1] || !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], s_tvalid};
    end
  end

  // Stage 1: exposure select, uptake difference, mu*g product
  logic [31:0] in_dmg, in_conc, x1;
  logic [33:0] diff1;
  logic [31:0] a_x, a_bio;
  logic [63:0] a_pgf;
  logic [32:0] a_mag;
  logic        a_neg;

  always_comb begin
    in_dmg  = s_tdata[63:32];
    in_conc = s_tdata[95:64];
    if (use_damage) begin
      x1 = (!in_dmg[31] && in_dmg != 32'd0) ? in_dmg : 32'd0;
    end else begin
      x1 = in_conc;
    end
    diff1 = {2'b00, in_conc} - {{2{in_dmg[31]}}, in_dmg};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x   <= x1;
      a_bio <= s_tdata[31:0];
      a_pgf <= 64'(growth_rate_max) * 64'(s_tdata[127:96]);
      a_neg <= diff1[33];
      a_mag <= diff1[33] ? 33'(-diff1) : diff1[32:0];
    end
  end

  // Stage 2: normalize both log operands, round mu*g, uptake product
  logic [31:0] ec_eff;
  logic [4:0]  nx2, ne2;
  log_t        lx [LOG_N+1];
  log_t        le [LOG_N+1];
  logic [47:0] b_p1;
  logic [64:0] b_uprod;
  logic        b_neg;
  logic [31:0] b_bio;

  always_comb begin
    ec_eff = (ec50 == 32'd0) ? 32'd1 : ec50;
    nx2    = lead_one(a_x);
    ne2    = lead_one(ec_eff);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx[0].zero <= (a_x == 32'd0);
      lx[0].n    <= nx2;
      lx[0].m    <= a_x << (5'd31 - nx2);
      lx[0].frac <= '0;
      le[0].zero <= 1'b0;
      le[0].n    <= ne2;
      le[0].m    <= ec_eff << (5'd31 - ne2);
      le[0].frac <= '0;
      b_p1       <= 48'((a_pgf + 64'd32768) >> 16);
      b_uprod    <= 65'(uptake_rate) * 65'(a_mag);
      b_neg      <= a_neg;
      b_bio      <= a_bio;
    end
  end

  // Log2 squaring chains
  for (genvar j = 0; j < LOG_N; j++) begin : g_log
    agd_log_cell #(.BIT(LOG_N - 1 - j)) u_lx (
      .clk(clk), .en(adv), .din(lx[j]), .dout(lx[j+1])
    );
    agd_log_cell #(.BIT(LOG_N - 1 - j)) u_le (
      .clk(clk), .en(adv), .din(le[j]), .dout(le[j+1])
    );
  end

  // Damage rate, then carry rate data to the end of the curve pipeline
  logic [49:0] r3;
  logic [31:0] drate3;
  rs_t         rs_in, rs_out;

  always_comb begin
    r3 = 50'((66'(b_uprod) + 66'd32768) >> 16);
    if (!use_damage) begin
      drate3 = 32'd0;
    end else if (b_neg) begin
      drate3 = (r3 > 50'h8000_0000) ? SAT_NEG : 32'(-r3);
    end else begin
      drate3 = (r3 > 50'(SAT_POS)) ? SAT_POS : r3[31:0];
    end
    rs_in.bio   = b_bio;
    rs_in.p1    = b_p1;
    rs_in.drate = drate3;
  end

  agd_delay #(.W($bits(rs_t)), .D(RS_DEPTH + 1)) u_rs (
    .clk(clk), .en(adv), .din(rs_in), .dout(rs_out)
  );

  // Log difference and its magnitude
  logic [21:0] d19;
  logic [20:0] d_ad;
  logic        d_pos, d_xz;

  always_comb begin
    d19 = {1'b0, lx[LOG_N].n, lx[LOG_N].frac} - {1'b0, le[LOG_N].n, le[LOG_N].frac};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_pos <= !d19[21];
      d_ad  <= d19[21] ? 21'(-d19) : d19[20:0];
      d_xz  <= lx[LOG_N].zero;
    end
  end

  // Scale by slope
  logic [36:0] e_u;
  logic        e_pos, e_xz;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_u   <= 37'((54'(slope) * 54'(d_ad) + 54'd32768) >> 16);
      e_pos <= d_pos;
      e_xz  <= d_xz;
    end
  end

  // Probit argument a = u*ln2
  logic [20:0] uc21;
  logic [33:0] q1_a30;
  logic [36:0] q1_u;
  logic        q1_pos, q1_xz;

  always_comb begin
    uc21 = (e_u > 37'(21'h10_0000)) ? 21'h10_0000 : e_u[20:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_a30 <= 34'((51'(uc21) * 51'(LN2_Q30)) >> 16);
      q1_u   <= e_u;
      q1_pos <= e_pos;
      q1_xz  <= e_xz;
    end
  end

  // Square of a and the divisor 1 + p*a
  logic [23:0] q2_sq16;
  logic [31:0] q2_pden;
  logic        q2_small;
  logic [36:0] q2_u;
  logic        q2_pos, q2_xz;
  logic [19:0] a16;

  assign a16 = q1_a30[33:14];

  always_ff @(posedge clk) begin
    if (adv) begin
      q2_sq16  <= 24'((40'(a16) * 40'(a16) + 40'd32768) >> 16);
      q2_pden  <= 32'(Q30_ONE)
                + 32'((62'(PROBIT_P_Q30) * 62'(q1_a30) + 62'd536870912) >> 30);
      q2_small <= !q1_a30[33];
      q2_u     <= q1_u;
      q2_pos   <= q1_pos;
      q2_xz    <= q1_xz;
    end
  end

  // Gaussian exponent a^2/2 in log2 units
  logic [23:0] q3_u2;
  logic [36:0] q3_u;
  logic [31:0] q3_pden;
  logic        q3_small, q3_pos, q3_xz;

  always_ff @(posedge clk) begin
    if (adv) begin
      q3_u2    <= 24'((54'(q2_sq16) * 54'(HALF_LOG2E_Q30) + 54'd536870912) >> 30);
      q3_u     <= q2_u;
      q3_pden  <= q2_pden;
      q3_small <= q2_small;
      q3_pos   <= q2_pos;
      q3_xz    <= q2_xz;
    end
  end

  // Power-of-two setup: integer shift and complemented fraction
  logic [36:0] w24;
  logic [20:0] wn;
  logic [15:0] wf;
  pow_t        pw [POW_N+1];
  logic [34:0] psb_in, psb_out;

  always_comb begin
    w24 = curve_mode ? 37'(q3_u2) : q3_u;
    wn  = w24[36:16];
    wf  = w24[15:0];
    psb_in = {q3_pden, q3_small, q3_pos, q3_xz};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pw[0].zero <= (wn >= 21'd40);
      pw[0].sh   <= (wf == 16'd0) ? wn[5:0] : 6'(wn[5:0] + 6'd1);
      pw[0].fp   <= 16'(17'h1_0000 - 17'(wf));
      pw[0].m    <= Q30_ONE;
    end
  end

  for (genvar j = 0; j < POW_N; j++) begin : g_pow
    agd_pow_cell #(.K(j + 1)) u_pow (
      .clk(clk), .en(adv), .din(pw[j]), .dout(pw[j+1])
    );
  end

  agd_delay #(.W(35), .D(POW_N + 1)) u_psb (
    .clk(clk), .en(adv), .din(psb_in), .dout(psb_out)
  );

  // Final shift of 2^-u
  logic [30:0] r_e;
  logic [31:0] r_pden;
  logic        r_small, r_pos, r_xz;

  always_ff @(posedge clk) begin
    if (adv) begin
      r_e     <= pw[POW_N].zero ? 31'd0 : 31'(pw[POW_N].m >> pw[POW_N].sh);
      r_pden  <= psb_out[34:3];
      r_small <= psb_out[2];
      r_pos   <= psb_out[1];
      r_xz    <= psb_out[0];
    end
  end

  // Divider setup: logistic ratio or probit 1/(1+p*a); density phi
  logic [29:0] phi42;
  logic [31:0] den_l;
  logic [46:0] num_l;
  logic [60:0] nn42;
  logic [31:0] dd42;
  div_t        dv [DIV_N+1];
  logic [32:0] dsb_in, dsb_out;

  always_comb begin
    phi42 = 30'((61'(r_e) * 61'(INV_SQRT_2PI_Q30) + 61'd536870912) >> 30);
    den_l = 32'(Q30_ONE) + 32'(r_e);
    num_l = r_pos ? (47'(r_e) << 16) : (47'd1 << 46);
    if (curve_mode) begin
      nn42 = (61'd1 << 60) + 61'(r_pden >> 1);
      dd42 = r_pden;
    end else begin
      nn42 = 61'(num_l) + 61'(den_l >> 1);
      dd42 = den_l;
    end
    dsb_in = {phi42, r_pos, r_small, r_xz};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].rem <= 32'(nn42 >> 31);
      dv[0].num <= nn42[30:0];
      dv[0].den <= dd42;
      dv[0].quo <= '0;
    end
  end

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    agd_div_cell #(.BIT(DIV_N - 1 - j)) u_div (
      .clk(clk), .en(adv), .din(dv[j]), .dout(dv[j+1])
    );
  end

  agd_delay #(.W(33), .D(DIV_N + 1)) u_dsb (
    .clk(clk), .en(adv), .din(dsb_in), .dout(dsb_out)
  );

  // Horner evaluation of the tail polynomial in k
  hz_t                hs0;
  hz_t                hs [1:6];
  logic signed [35:0] hacc [1:5];
  logic signed [35:0] qv;

  always_comb begin
    hs0.k       = dv[DIV_N].quo;
    hs0.phi     = dsb_out[32:3];
    hs0.pos     = dsb_out[2];
    hs0.tail_ok = dsb_out[1];
    hs0.xzero   = dsb_out[0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hs[1]   <= hs0;
      hacc[1] <= CB4 + mul_q30(CB5, hs0.k);
      hs[2]   <= hs[1];
      hacc[2] <= CB3 + mul_q30(hacc[1], hs[1].k);
      hs[3]   <= hs[2];
      hacc[3] <= CB2 + mul_q30(hacc[2], hs[2].k);
      hs[4]   <= hs[3];
      hacc[4] <= CB1 + mul_q30(hacc[3], hs[3].k);
      hs[5]   <= hs[4];
      hacc[5] <= mul_q30(hacc[4], hs[4].k);
      hs[6]   <= hs[5];
      qv      <= mul_q30(hacc[5], 31'(hs[5].phi));
    end
  end

  // Clamp tail, pick curve, force one at zero exposure
  logic [30:0] qc, f30;
  logic [16:0] fp17, f80, f_reg;

  always_comb begin
    if (!hs[6].tail_ok || qv[35]) begin
      qc = 31'd0;
    end else if (qv > 36'sd1073741824) begin
      qc = Q30_ONE;
    end else begin
      qc = qv[30:0];
    end
    f30  = hs[6].pos ? qc : 31'(Q30_ONE - qc);
    fp17 = 17'((32'(f30) + 32'd8192) >> 14);
    if (hs[6].xzero) begin
      f80 = 17'h1_0000;
    end else if (curve_mode) begin
      f80 = fp17;
    end else begin
      f80 = hs[6].k[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_reg <= f80;
    end
  end

  // Apply inhibition, clip to the saturating range
  logic [48:0] p2;
  logic [46:0] p2c;
  logic [31:0] g_bio, g_drate;

  assign p2 = 49'((65'(rs_out.p1) * 65'(f_reg) + 65'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (adv) begin
      p2c     <= p2[48:47] != 2'b00 ? {47{1'b1}} : p2[46:0];
      g_bio   <= rs_out.bio;
      g_drate <= rs_out.drate;
    end
  end

  // Partial products with biomass
  logic [63:0] h_lo;
  logic [46:0] h_hi;
  logic [31:0] h_drate;

  always_ff @(posedge clk) begin
    if (adv) begin
      h_lo    <= 64'(p2c[31:0]) * 64'(g_bio);
      h_hi    <= 47'(p2c[46:32]) * 47'(g_bio);
      h_drate <= g_drate;
    end
  end

  // Sum, round, saturate into the output register
  logic [79:0] bsum;
  logic [63:0] bq;
  logic [31:0] brate;

  always_comb begin
    bsum  = {h_hi, 32'd0} + 80'(h_lo) + 80'd32768;
    bq    = 64'(bsum >> 16);
    brate = (bq > 64'(SAT_POS)) ? SAT_POS : bq[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (vld[STAGES-1] && (!m_tvalid || m_tready)) begin
      m_tdata <= {h_drate, brate};
    end
  end

endmodule

FILE: hw/rtl/agd_checker.sv
// Port-level checks for the algae growth derivative, bound to the top level.
module agd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [127:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata
);

  // No result beat right after reset
  a_rst_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // An empty output register never blocks input
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Biomass rate is never negative
  a_brate_sign : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[31])
    else $error("negative biomass rate");

  // Hold a stalled result beat
  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

endmodule

bind algae_growth_derivative agd_checker u_agd_checker (.*);

FILE: sim/agd_growth_checker.sv
// Checker for the algae growth derivative: predicts rates from each input beat and compares.
module agd_growth_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [agd_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [31:0]  cfg_wdata,
  output int           fail_count,
  output int           pending_rates
);
  import agd_pkg::*;

  typedef struct packed {
    logic [31:0] damage_rate;
    logic [31:0] biomass_rate;
  } rates_t;

  // Mirror of the configuration registers
  logic [63:0] mu_max, half_conc, dose_slope, k_uptake;
  logic        damage_mode, probit_mode;

  rates_t rate_queue[$];

  localparam logic [63:0] ONE30 = 64'd1073741824;
  localparam logic [63:0] SAT_HI = 64'd2147483647;

  // Root values 2^(30 + 2^-k)
  function automatic logic [63:0] frac_root(input int k);
    return 64'(pow2_frac(4'(k - 1)));
  endfunction

  // log2 in Q16, truncated, by repeated squaring
  function automatic longint log2_fix(input logic [63:0] v);
    int n;
    logic [63:0] m;
    longint fr;
    n = 31;
    fr = 0;
    while (n > 0 && v[n] == 1'b0) n--;
    m = v << (31 - n);
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        fr |= longint'(1) << i;
        m = m >> 1;
      end
    end
    return longint'(n) * 65536 + fr;
  endfunction

  // 2^-u with u in Q16, result Q30
  function automatic logic [63:0] exp2_neg(input logic [63:0] u);
    logic [63:0] n, f, fp, m;
    n = u >> 16;
    f = u & 64'hFFFF;
    m = ONE30;
    if (n >= 40) return 64'd0;
    if (f == 0) return ONE30 >> n;
    fp = 64'd65536 - f;
    for (int k = 1; k <= 16; k++)
      if (fp[16 - k]) m = (m * frac_root(k) + (64'd1 << 29)) >> 30;
    return m >> (n + 1);
  endfunction

  // Signed Q30 product, rounded half away from zero
  function automatic longint smul30(input longint a, input longint b);
    logic neg;
    logic [63:0] ma, mb, r;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? 64'(-a) : 64'(a);
    mb = b < 0 ? 64'(-b) : 64'(b);
    r = (ma * mb + (64'd1 << 29)) >> 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Inhibition factor in Q16 for a raw exposure
  function automatic logic [63:0] inhibition(input logic [63:0] x);
    logic [63:0] ec, ad, u, e, den, num, uc, a30, den2, a16, sq, u2, phi, f30;
    longint d, kk, acc, q;
    logic pos;
    ec = (half_conc != 0) ? half_conc : 64'd1;
    if (x == 0) return 64'd65536;
    d = log2_fix(x) - log2_fix(ec);
    pos = d >= 0;
    ad = pos ? 64'(d) : 64'(-d);
    u = (dose_slope * ad + (64'd1 << 15)) >> 16;
    if (!probit_mode) begin
      e = exp2_neg(u);
      den = ONE30 + e;
      num = pos ? (e << 16) : (ONE30 << 16);
      return (num + (den >> 1)) / den;
    end
    uc = (u > (64'd16 << 16)) ? (64'd16 << 16) : u;
    a30 = (uc * 64'(LN2_Q30)) >> 16;
    q = 0;
    if (a30 < (64'd8 << 30)) begin
      den2 = ONE30 + ((64'(PROBIT_P_Q30) * a30 + (64'd1 << 29)) >> 30);
      kk = longint'(((64'd1 << 60) + (den2 >> 1)) / den2);
      a16 = a30 >> 14;
      sq = (a16 * a16 + (64'd1 << 15)) >> 16;
      u2 = (sq * 64'(HALF_LOG2E_Q30) + (64'd1 << 29)) >> 30;
      phi = (exp2_neg(u2) * 64'(INV_SQRT_2PI_Q30) + (64'd1 << 29)) >> 30;
      acc = longint'(CB5);
      acc = longint'(CB4) + smul30(kk, acc);
      acc = longint'(CB3) + smul30(kk, acc);
      acc = longint'(CB2) + smul30(kk, acc);
      acc = longint'(CB1) + smul30(kk, acc);
      acc = smul30(kk, acc);
      q = smul30(longint'(phi), acc);
      if (q < 0) q = 0;
      if (q > longint'(ONE30)) q = longint'(ONE30);
    end
    f30 = pos ? 64'(q) : ONE30 - 64'(q);
    return (f30 + (64'd1 << 13)) >> 14;
  endfunction

  // Biomass and damage derivatives for one input beat
  function automatic rates_t predict_rates(input logic [127:0] beat);
    logic [63:0] bio, conc, gf, x, f, p1, p2, br, mag, r;
    longint dmg, diff, dr;
    rates_t res;
    bio  = 64'(beat[31:0]);
    dmg  = longint'($signed(beat[63:32]));
    conc = 64'(beat[95:64]);
    gf   = 64'(beat[127:96]);
    dr = 0;
    x = damage_mode ? (dmg > 0 ? 64'(dmg) : 64'd0) : conc;
    f = inhibition(x);
    p1 = (mu_max * gf + (64'd1 << 15)) >> 16;
    p2 = (p1 * f + (64'd1 << 15)) >> 16;
    if (bio != 0 && p2 > (64'hFFFF_FFFF_FFFF_FFFF - (64'd1 << 15)) / bio) br = SAT_HI;
    else begin
      br = (p2 * bio + (64'd1 << 15)) >> 16;
      if (br > SAT_HI) br = SAT_HI;
    end
    if (damage_mode) begin
      diff = longint'(conc) - dmg;
      mag = diff < 0 ? 64'(-diff) : 64'(diff);
      if (k_uptake != 0 && mag > (64'hFFFF_FFFF_FFFF_FFFF - (64'd1 << 15)) / k_uptake)
        dr = diff < 0 ? -longint'(64'd2147483648) : longint'(SAT_HI);
      else begin
        r = (k_uptake * mag + (64'd1 << 15)) >> 16;
        if (diff < 0) dr = r > 64'd2147483648 ? -longint'(64'd2147483648) : -longint'(r);
        else dr = r > SAT_HI ? longint'(SAT_HI) : longint'(r);
      end
    end
    res.biomass_rate = br[31:0];
    res.damage_rate = 32'(dr);
    return res;
  endfunction

  assign pending_rates = rate_queue.size();

  // Track configuration, predict on input beats, compare on output beats
  always @(posedge clk) begin
    rates_t want, got;
    if (rst) begin
      mu_max <= 64'd65536;
      half_conc <= 64'd65536;
      dose_slope <= 64'd65536;
      k_uptake <= 64'd0;
      damage_mode <= 1'b0;
      probit_mode <= 1'b0;
      rate_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_GROWTH_RATE_MAX: mu_max <= 64'(cfg_wdata);
          REG_EC50:            half_conc <= 64'(cfg_wdata);
          REG_SLOPE:           dose_slope <= 64'(cfg_wdata);
          REG_UPTAKE_RATE:     k_uptake <= 64'(cfg_wdata);
          REG_USE_DAMAGE:      damage_mode <= cfg_wdata[0];
          REG_CURVE_MODE:      probit_mode <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) rate_queue.push_back(predict_rates(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (rate_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected output beat %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = rate_queue.pop_front();
          if (got.biomass_rate !== want.biomass_rate || got.damage_rate !== want.damage_rate)
          begin
            if (fail_count < 10)
              $display("rate mismatch: biomass exp %h got %h, damage exp %h got %h",
                       want.biomass_rate, got.biomass_rate, want.damage_rate,
                       got.damage_rate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: sim/tb_algae_growth_derivative.sv
// Testbench top for the algae growth derivative: stimulus, configuration phases and verdict.
module tb_algae_growth_derivative;
  import agd_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;
  int           fail_count;
  int           pending_rates;
  logic         calm = 1'b0;

  always #2 clk = ~clk;

  algae_growth_derivative dut (.*);

  agd_growth_checker checker_i (.*);

  // Drain side: random stall bursts, none in the final stretch
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 4);
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Write one register while the pipeline is idle
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for all outstanding rates plus pipeline slack
  task automatic drain_pipe();
    while (pending_rates != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Present one beat, holding valid until the edge that accepts it
  task automatic send_state(input logic [31:0] bio, input logic [31:0] dmg,
                            input logic [31:0] conc, input logic [31:0] gf);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {gf, conc, dmg, bio};
    @(posedge clk iff s_tready);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0003_FFFF);
      3: return 32'h0001_0000 + $urandom_range(0, 32'hFFFF) - 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  // Random beat mix, kept mostly in a meaningful range
  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_state(pick_word(), ($urandom_range(0, 1) ? pick_word() : -$urandom_range(0, 32'h3_0000)),
                 pick_word(), ($urandom_range(0, 3) == 0 ? pick_word()
                                                        : $urandom_range(0, 32'h2_0000)));
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic setup_regs(input logic [31:0] mu, input logic [31:0] ec,
                            input logic [31:0] b, input logic [31:0] kd,
                            input logic dm, input logic pm);
    write_reg(REG_GROWTH_RATE_MAX, mu);
    write_reg(REG_EC50, ec);
    write_reg(REG_SLOPE, b);
    write_reg(REG_UPTAKE_RATE, kd);
    write_reg(REG_USE_DAMAGE, {31'd0, dm});
    write_reg(REG_CURVE_MODE, {31'd0, pm});
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset configuration, extremes and zero exposure
    send_state(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
    send_state(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_state(32'h0, 32'h8000_0000, 32'h0000_0001, 32'h0);
    send_state(32'h0002_0000, 32'h7FFF_FFFF, 32'h0004_0000, 32'h0001_0000);
    send_state(32'h0001_0000, 32'h0, 32'h0000_8000, 32'h0001_0000);
    s_tvalid <= 1'b0;
    drain_pipe();

    // Damage mode, probit, zero ec50 and zero slope
    setup_regs(32'h0002_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_state(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000);
    send_state(32'h0001_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000);
    send_state(32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000);
    send_state(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
    s_tvalid <= 1'b0;
    drain_pipe();

    setup_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1, 1'b0);
    send_state(32'hFFFF_FFFF, 32'h0000_0001, 32'h0002_0000, 32'hFFFF_FFFF);
    send_state(32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000);
    send_random(60);
    drain_pipe();

    // Random phases over several settings
    setup_regs(32'h0000_8000, 32'h0002_0000, 32'h0002_0000, 32'h0000_4000, 1'b0, 1'b1);
    send_random(90);
    drain_pipe();
    setup_regs(32'h0001_8000, 32'h0000_4000, 32'h0000_4000, 32'h0003_0000, 1'b1, 1'b1);
    send_random(90);
    drain_pipe();
    setup_regs($urandom, $urandom_range(1, 32'h4_0000), $urandom_range(0, 32'h8_0000),
               $urandom, 1'b0, 1'b0);
    send_random(90);
    drain_pipe();

    // Final stretch without idling
    calm <= 1'b1;
    setup_regs(32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 1'b1, 1'b0);
    send_random(100);
    drain_pipe();

    if (fail_count == 0) begin
      $display("tb_algae_growth_derivative OK");
    end else begin
      $display("tb_algae_growth_derivative NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("tb_algae_growth_derivative NOT OK");
    $finish;
  end

endmodule
